// ===== src/gec_pkg.sv =====
// shared constants, codes and types of the greedy element coloring unit
package gec_pkg;

  // fixed field widths of the item channels
  localparam int unsigned KindW     = 2;
  localparam int unsigned DofW      = 12;
  localparam int unsigned ElemIdxW  = 16;
  localparam int unsigned ColorOutW = 4;
  localparam int unsigned CountOutW = 5;

  // largest DOF index space the 12-bit field can address
  localparam int unsigned DofSpace = 4096;

  // parameter defaults
  localparam int unsigned NumDofsDef           = 4096;
  localparam int unsigned MaxColorsDef         = 16;
  localparam int unsigned MaxDofsPerElementDef = 32;
  localparam int unsigned MaxElementsDef       = 65536;

  // input item kinds
  typedef enum logic [KindW-1:0] {
    KindDof     = 2'd0,
    KindClose   = 2'd1,
    KindRestart = 2'd2
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StAcc,
    StChoose,
    StWalk,
    StEmit
  } state_e;

  // control of the pending DOF buffer
  typedef struct packed {
    logic push;
    logic clear;
    logic rd_en;
  } buf_ctrl_t;

endpackage

// ===== src/gec_if.sv =====
// valid/ready channel interfaces for input and result items
interface gec_in_if import gec_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [DofW-1:0]     dof_index;
  logic                last_of_element;

  modport source (output valid, kind, dof_index, last_of_element, input ready);
  modport sink   (input valid, kind, dof_index, last_of_element, output ready);
endinterface

interface gec_out_if import gec_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ElemIdxW-1:0]  element_index;
  logic [ColorOutW-1:0] color;
  logic [CountOutW-1:0] color_count;
  logic                 overflow;

  modport source (output valid, element_index, color, color_count, overflow, input ready);
  modport sink   (input valid, element_index, color, color_count, overflow, output ready);
endinterface

// ===== src/greedy_element_coloring_unit.sv =====
// top level of the streaming greedy element coloring unit
// usage:
//   in_i carries items: a DOF of the open element (optionally marked as the
//   last one), a close with no further DOFs, or a restart of the mesh.
//   out_o carries one item per closed element: its sequence number, its
//   color, the number of colors in use and an overflow flag.
// item handling:
//   a DOF item takes one read of the mask memory, then the merge into the
//   element's used-color mask. closing an element chooses the color, then
//   walks the buffered DOFs and sets the color bit in each mask (one read-
//   modify-write of the single mask memory port pair per cycle), and then
//   hands the result off.
//   the input is not ready while an item is being worked on.
// reset and restart:
//   both start a clearing pass over the mask memory, one word per cycle,
//   covering NUM_DOFS words (capped at 4096); no item is taken during the pass.
// stalls:
//   the result sits in an output register; DOF items keep flowing while it
//   waits, and only the next close waits for the register to free up.
module greedy_element_coloring_unit import gec_pkg::*; #(
  parameter int unsigned NUM_DOFS             = NumDofsDef,
  parameter int unsigned MAX_COLORS           = MaxColorsDef,
  parameter int unsigned MAX_DOFS_PER_ELEMENT = MaxDofsPerElementDef,
  parameter int unsigned MAX_ELEMENTS         = MaxElementsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gec_in_if.sink    in_i,
  gec_out_if.source out_o
);

  // mask memory only needs the DOFs the index field can name
  localparam int unsigned MemDepth = (NUM_DOFS < DofSpace) ? NUM_DOFS : DofSpace;
  localparam int unsigned MemAw    = $clog2(MemDepth);
  localparam int unsigned BufAw    = (MAX_DOFS_PER_ELEMENT > 1) ?
                                     $clog2(MAX_DOFS_PER_ELEMENT) : 1;
  localparam int unsigned BufCntW  = $clog2(MAX_DOFS_PER_ELEMENT + 1);
  localparam int unsigned ColW     = $clog2(MAX_COLORS);
  localparam int unsigned CiuW     = $clog2(MAX_COLORS + 1);
  localparam int unsigned ElemW    = $clog2(MAX_ELEMENTS);

  state_e                state_q, state_d;
  logic [MemAw-1:0]      clr_addr_q, clr_addr_d;
  logic [MAX_COLORS-1:0] used_q, used_d;
  logic                  last_q, last_d;
  logic [BufCntW-1:0]    walk_idx_q, walk_idx_d;
  logic                  s1_v_q, s1_v_d;
  logic                  s2_v_q, s2_v_d;
  logic [MemAw-1:0]      s2_addr_q, s2_addr_d;
  logic [ElemW-1:0]      elem_q, elem_d;
  logic [CiuW-1:0]       ciu_q, ciu_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [ElemIdxW-1:0]   out_idx_q, out_idx_d;
  logic [ColorOutW-1:0]  out_color_q, out_color_d;
  logic [CountOutW-1:0]  out_count_q, out_count_d;
  logic                  out_ovf_q, out_ovf_d;

  // mask memory port
  logic                  mem_rd_en;
  logic [MemAw-1:0]      mem_rd_addr;
  logic [MAX_COLORS-1:0] mem_rd_data;
  logic                  mem_wr_en;
  logic                  mem_wr_clear;
  logic [MemAw-1:0]      mem_wr_addr;
  logic [MAX_COLORS-1:0] set_mask;

  // pending buffer port
  buf_ctrl_t             buf_ctrl;
  logic [MemAw-1:0]      buf_rd_data;
  logic [BufCntW-1:0]    buf_count;
  logic                  buf_ovf;

  // color search
  logic                  pick_found;
  logic [ColW-1:0]       pick_color;
  logic [CiuW-1:0]       pick_ciu;
  logic                  res_ovf;

  logic                  dof_ok;
  logic                  issue;
  logic                  out_free;

  assign dof_ok   = (32'(in_i.dof_index) < 32'(MemDepth));
  assign set_mask = {{(MAX_COLORS-1){1'b0}}, 1'b1} << pick_color;
  assign res_ovf  = buf_ovf | ~pick_found;
  assign issue    = (walk_idx_q < buf_count);
  assign out_free = ~out_valid_q | out_o.ready;

  gec_mask_mem #(
    .DEPTH (MemDepth),
    .WIDTH (MAX_COLORS),
    .AW    (MemAw)
  ) u_mask_mem (
    .clk_i      (clk_i),
    .rd_en_i    (mem_rd_en),
    .rd_addr_i  (mem_rd_addr),
    .rd_data_o  (mem_rd_data),
    .wr_en_i    (mem_wr_en),
    .wr_clear_i (mem_wr_clear),
    .wr_addr_i  (mem_wr_addr),
    .set_mask_i (set_mask)
  );

  gec_pend_buf #(
    .DEPTH (MAX_DOFS_PER_ELEMENT),
    .AW    (BufAw),
    .CNTW  (BufCntW),
    .DW    (MemAw)
  ) u_pend_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (buf_ctrl),
    .wr_data_i (in_i.dof_index[MemAw-1:0]),
    .rd_idx_i  (walk_idx_q[BufAw-1:0]),
    .rd_data_o (buf_rd_data),
    .count_o   (buf_count),
    .ovf_o     (buf_ovf)
  );

  gec_color_pick #(
    .MAX_COLORS (MAX_COLORS),
    .COLW       (ColW),
    .CIUW       (CiuW)
  ) u_color_pick (
    .used_i  (used_q),
    .ciu_i   (ciu_q),
    .found_o (pick_found),
    .color_o (pick_color),
    .ciu_o   (pick_ciu)
  );

  // sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    used_d       = used_q;
    last_d       = last_q;
    walk_idx_d   = walk_idx_q;
    s1_v_d       = 1'b0;
    s2_v_d       = 1'b0;
    s2_addr_d    = s2_addr_q;
    elem_d       = elem_q;
    ciu_d        = ciu_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    out_idx_d    = out_idx_q;
    out_color_d  = out_color_q;
    out_count_d  = out_count_q;
    out_ovf_d    = out_ovf_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = in_i.dof_index[MemAw-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_clear = 1'b0;
    mem_wr_addr  = s2_addr_q;
    buf_ctrl     = '0;
    in_i.ready   = 1'b0;

    unique case (state_q)
      // zero one mask word per cycle
      StClear: begin
        mem_wr_en    = 1'b1;
        mem_wr_clear = 1'b1;
        mem_wr_addr  = clr_addr_q;
        if (clr_addr_q == MemAw'(MemDepth - 1)) begin
          clr_addr_d = '0;
          state_d    = StIdle;
        end else begin
          clr_addr_d = clr_addr_q + MemAw'(1);
        end
      end

      StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          unique case (in_i.kind)
            KindDof: begin
              if (dof_ok) begin
                mem_rd_en     = 1'b1;
                buf_ctrl.push = 1'b1;
                last_d        = in_i.last_of_element;
                state_d       = StAcc;
              end else if (in_i.last_of_element) begin
                state_d = StChoose;
              end
            end
            KindClose: begin
              state_d = StChoose;
            end
            KindRestart: begin
              buf_ctrl.clear = 1'b1;
              used_d         = '0;
              elem_d         = '0;
              ciu_d          = '0;
              clr_addr_d     = '0;
              state_d        = StClear;
            end
            default: begin
              // unused kind, dropped
            end
          endcase
        end
      end

      // merge the DOF's mask into the element's used colors
      StAcc: begin
        used_d  = used_q | mem_rd_data;
        state_d = last_q ? StChoose : StIdle;
      end

      StChoose: begin
        walk_idx_d = '0;
        if (res_ovf || (buf_count == '0)) begin
          state_d = StEmit;
        end else begin
          state_d = StWalk;
        end
      end

      // three-stage walk: buffer read, mask read, mask write
      StWalk: begin
        if (issue) begin
          buf_ctrl.rd_en = 1'b1;
          walk_idx_d     = walk_idx_q + BufCntW'(1);
          s1_v_d         = 1'b1;
        end
        if (s1_v_q) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = buf_rd_data;
          s2_v_d      = 1'b1;
          s2_addr_d   = buf_rd_data;
        end
        if (s2_v_q) begin
          mem_wr_en = 1'b1;
        end
        if (!issue && !s1_v_q && !s2_v_q) begin
          state_d = StEmit;
        end
      end

      StEmit: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_idx_d      = ElemIdxW'(elem_q);
          out_ovf_d      = res_ovf;
          out_color_d    = res_ovf ? '0 : ColorOutW'(pick_color);
          out_count_d    = res_ovf ? CountOutW'(ciu_q) : CountOutW'(pick_ciu);
          if (!res_ovf) begin
            ciu_d = pick_ciu;
          end
          elem_d         = (elem_q == ElemW'(MAX_ELEMENTS - 1)) ? '0 : elem_q + ElemW'(1);
          buf_ctrl.clear = 1'b1;
          used_d         = '0;
          state_d        = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_addr_q  <= '0;
      used_q      <= '0;
      last_q      <= 1'b0;
      walk_idx_q  <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      elem_q      <= '0;
      ciu_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      used_q      <= used_d;
      last_q      <= last_d;
      walk_idx_q  <= walk_idx_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      elem_q      <= elem_d;
      ciu_q       <= ciu_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    s2_addr_q   <= s2_addr_d;
    out_idx_q   <= out_idx_d;
    out_color_q <= out_color_d;
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.element_index = out_idx_q;
  assign out_o.color         = out_color_q;
  assign out_o.color_count   = out_count_q;
  assign out_o.overflow      = out_ovf_q;

endmodule

// ===== src/gec_mask_mem.sv =====
// per-DOF used-color mask memory with read-modify-write set and clear
module gec_mask_mem import gec_pkg::*; #(
  parameter int unsigned DEPTH = NumDofsDef,
  parameter int unsigned WIDTH = MaxColorsDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic             wr_clear_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] set_mask_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write merges the color bit into the word read the cycle before
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_clear_i ? '0 : (rd_data_q | set_mask_i);
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/gec_pend_buf.sv =====
// buffer of the DOFs of the open element, with fill count and overflow flag
module gec_pend_buf import gec_pkg::*; #(
  parameter int unsigned DEPTH = MaxDofsPerElementDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CNTW  = $clog2(DEPTH + 1),
  parameter int unsigned DW    = DofW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  buf_ctrl_t       ctrl_i,
  input  logic [DW-1:0]   wr_data_i,
  input  logic [AW-1:0]   rd_idx_i,
  output logic [DW-1:0]   rd_data_o,
  output logic [CNTW-1:0] count_o,
  output logic            ovf_o
);

  logic [DW-1:0]   mem [DEPTH];
  logic [DW-1:0]   rd_data_q;
  logic [CNTW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            room;

  assign room = (count_q < CNTW'(DEPTH));

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctrl_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (ctrl_i.push) begin
      if (room) begin
        count_d = count_q + CNTW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear && room) begin
      mem[count_q[AW-1:0]] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;
  assign ovf_o     = ovf_q;

endmodule

// ===== src/gec_color_pick.sv =====
// lowest free color search and running color count update
module gec_color_pick import gec_pkg::*; #(
  parameter int unsigned MAX_COLORS = MaxColorsDef,
  parameter int unsigned COLW       = $clog2(MAX_COLORS),
  parameter int unsigned CIUW       = $clog2(MAX_COLORS + 1)
) (
  input  logic [MAX_COLORS-1:0] used_i,
  input  logic [CIUW-1:0]       ciu_i,
  output logic                  found_o,
  output logic [COLW-1:0]       color_o,
  output logic [CIUW-1:0]       ciu_o
);

  logic [CIUW-1:0] next_top;

  // priority encoder, lowest clear bit wins
  always_comb begin
    found_o = 1'b0;
    color_o = '0;
    for (int i = MAX_COLORS - 1; i >= 0; i--) begin
      if (!used_i[i]) begin
        found_o = 1'b1;
        color_o = COLW'(i);
      end
    end
  end

  assign next_top = CIUW'(color_o) + CIUW'(1);
  assign ciu_o    = (next_top > ciu_i) ? next_top : ciu_i;

endmodule
